// File: rtl/spq_pkg.sv
// Package for the sorted priority queue: transaction structs, codes and defaults.
// No dependencies; every other file in rtl imports it.
`default_nettype none

package spq_pkg;

   localparam int CAPACITY_DEFAULT    = 16;
   localparam int VALUE_WIDTH_DEFAULT = 32;

   // Request modes.
   localparam logic MODE_INSERT = 1'b0;
   localparam logic MODE_POP    = 1'b1;

   // Response status codes.
   localparam logic [1:0] STATUS_OK    = 2'd0;
   localparam logic [1:0] STATUS_EMPTY = 2'd1;
   localparam logic [1:0] STATUS_FULL  = 2'd2;

   typedef struct packed {
      logic               mode;
      logic signed [31:0] value;
   } req_type;

   typedef struct packed {
      logic signed [31:0] pop_value;
      logic               pop_valid;
      logic [1:0]         status;
      logic [4:0]         occupancy;
   } rsp_type;

   typedef enum logic [1:0] {
      OP_HOLD,
      OP_INSERT,
      OP_POP
   } op_type;

   typedef struct packed {
      op_type op;
   } cell_ctl_type;

endpackage

`default_nettype wire

// File: rtl/spq_cell.sv
// One storage cell of the sorted priority queue chain.
// Depends on spq_pkg for the cell control struct.
`default_nettype none

module spq_cell #(
   parameter int VALUE_WIDTH = spq_pkg::VALUE_WIDTH_DEFAULT
) (
   input  wire                              clock,
   input  wire spq_pkg::cell_ctl_type       ctl,
   input  wire                              cell_valid,
   input  wire  signed [VALUE_WIDTH-1:0]    new_value,
   input  wire  signed [VALUE_WIDTH-1:0]    left_entry,
   input  wire                              left_go,
   input  wire  signed [VALUE_WIDTH-1:0]    right_entry,
   output logic signed [VALUE_WIDTH-1:0]    entry,
   output logic                             go
);
   import spq_pkg::*;

   logic signed [VALUE_WIDTH-1:0] entry_ff;
   logic signed [VALUE_WIDTH-1:0] entry_in;

   // An empty cell always lies at or beyond the insertion point.
   assign go    = !cell_valid || (entry_ff <= new_value);
   assign entry = entry_ff;

   always_comb begin
      entry_in = entry_ff;
      case (ctl.op)
         OP_INSERT: begin
            if (left_go) begin
               entry_in = left_entry;
            end else if (go) begin
               entry_in = new_value;
            end
         end
         OP_POP: begin
            entry_in = right_entry;
         end
         default: begin
            entry_in = entry_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

endmodule

`default_nettype wire

// File: rtl/sorted_priority_queue.sv
// Top level of the sorted priority queue: a chain of spq_cell instances kept in
// descending order, an occupancy counter and a registered response stage.
// Depends on spq_pkg and spq_cell.
//
//   Channel   Direction   Ports                              Payload
//   request   in          req_valid, req_stall, req_data     req_type
//   response  out         rsp_valid, rsp_stall, rsp_data     rsp_type
//
// Every accepted transaction gives exactly one response, in the cycle after it is accepted.
// All cells compare against the new value in parallel, so one transaction can be accepted
// in every cycle while no response is held by rsp_stall; the throughput is set by the single response register.
// Reset clears the occupancy counter and the response valid flag; stored entries
// need no clearing since only entries below the occupancy are ever read.
// The request side is stalled only while a response is held and itself stalled.
`default_nettype none

module sorted_priority_queue #(
   parameter int CAPACITY    = spq_pkg::CAPACITY_DEFAULT,
   parameter int VALUE_WIDTH = spq_pkg::VALUE_WIDTH_DEFAULT
) (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   req_valid,
   output logic                  req_stall,
   input  wire spq_pkg::req_type req_data,
   output logic                  rsp_valid,
   input  wire                   rsp_stall,
   output spq_pkg::rsp_type      rsp_data
);
   import spq_pkg::*;

   localparam int CW = $clog2(CAPACITY + 1);

   logic [CW-1:0] count_ff;
   logic [CW-1:0] count_in;
   logic          rsp_valid_ff;
   logic          rsp_valid_in;
   rsp_type       rsp_ff;
   rsp_type       rsp_in;

   logic          accept;
   logic          full;
   logic          empty;
   cell_ctl_type  ctl;

   logic signed [63:0]            value_wide;
   logic signed [VALUE_WIDTH-1:0] insert_value;
   logic signed [63:0]            head_wide;

   logic signed [VALUE_WIDTH-1:0] entry [CAPACITY];
   logic                          go    [CAPACITY];

   assign accept = req_valid && !req_stall;
   assign full   = (count_ff == CW'(CAPACITY));
   assign empty  = (count_ff == '0);

   // Narrow inputs keep their low bits; wide stores sign-extend the 32-bit field.
   assign value_wide   = 64'(req_data.value);
   assign insert_value = value_wide[VALUE_WIDTH-1:0];
   assign head_wide    = 64'(entry[0]);

   always_comb begin
      ctl.op = OP_HOLD;
      if (accept) begin
         if (req_data.mode == MODE_INSERT && !full) begin
            ctl.op = OP_INSERT;
         end else if (req_data.mode == MODE_POP && !empty) begin
            ctl.op = OP_POP;
         end
      end
   end

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic signed [VALUE_WIDTH-1:0] left_entry;
      logic                          left_go;
      logic signed [VALUE_WIDTH-1:0] right_entry;

      if (i == 0) begin : g_head
         assign left_entry = insert_value;
         assign left_go    = 1'b0;
      end else begin : g_body
         assign left_entry = entry[i-1];
         assign left_go    = go[i-1];
      end

      if (i == CAPACITY - 1) begin : g_tail
         assign right_entry = entry[i];
      end else begin : g_inner
         assign right_entry = entry[i+1];
      end

      spq_cell #(
         .VALUE_WIDTH(VALUE_WIDTH)
      ) u_cell (
         .clock      (clock),
         .ctl        (ctl),
         .cell_valid (count_ff > CW'(i)),
         .new_value  (insert_value),
         .left_entry (left_entry),
         .left_go    (left_go),
         .right_entry(right_entry),
         .entry      (entry[i]),
         .go         (go[i])
      );
   end

   always_comb begin
      case (ctl.op)
         OP_INSERT: count_in = count_ff + CW'(1);
         OP_POP:    count_in = count_ff - CW'(1);
         default:   count_in = count_ff;
      endcase
   end

   always_comb begin
      rsp_in.pop_value = '0;
      rsp_in.pop_valid = 1'b0;
      rsp_in.status    = STATUS_OK;
      rsp_in.occupancy = 5'(count_in);
      if (req_data.mode == MODE_INSERT) begin
         if (full) begin
            rsp_in.status = STATUS_FULL;
         end
      end else begin
         if (empty) begin
            rsp_in.status = STATUS_EMPTY;
         end else begin
            rsp_in.pop_value = head_wide[31:0];
            rsp_in.pop_valid = 1'b1;
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (accept) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_ff <= rsp_in;
      end
   end

   assign req_stall = rsp_valid_ff && rsp_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // The counter never runs past the number of cells.
   assert property (@(posedge clock) disable iff (reset) count_ff <= CW'(CAPACITY))
      else $error("occupancy exceeds capacity");

   // A pop on a non-empty queue is answered next cycle with a removed value.
   assert property (@(posedge clock) disable iff (reset)
      (accept && req_data.mode == MODE_POP && !empty) |=> (rsp_valid && rsp_data.pop_valid))
      else $error("pop on non-empty queue gave no value");

   // The response occupancy agrees with the counter it was taken from.
   assert property (@(posedge clock) disable iff (reset)
      accept |=> (rsp_data.occupancy == 5'(count_ff)))
      else $error("response occupancy disagrees with counter");

   // Stored entries stay in descending order.
   for (genvar k = 0; k < CAPACITY - 1; k++) begin : g_order
      assert property (@(posedge clock) disable iff (reset)
         (count_ff > CW'(k + 1)) |-> (entry[k] >= entry[k+1]))
         else $error("entries out of order");
   end

endmodule

`default_nettype wire
